[hw/rtl/i2cdw_pkg.sv]
// Shared types and constants for the display write I2C master.
package i2cdw_pkg;

    // Frame geometry: address byte, control byte, payload byte.
    localparam int FRAME_BYTES = 3;
    localparam int FRAME_BITS  = FRAME_BYTES * 8;
    localparam int POS_W       = $clog2(FRAME_BITS);

    // Control byte values and the reset value of the phase length.
    localparam logic [7:0] CTRL_COMMAND = 8'h00;
    localparam logic [7:0] CTRL_DATA    = 8'h40;
    localparam logic [7:0] TICKS_RESET  = 8'd20;

    // Item kinds on the input stream.
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    // One classified item held in the queue between front and back.
    typedef struct packed {
        logic                  is_req;
        logic [FRAME_BITS-1:0] frame;
    } q_item_t;

    // One result item, highest bit first; scl_level is the lowest bit on the stream.
    typedef struct packed {
        logic done_res;
        logic accepted;
        logic busy_res;
        logic sda_level;
        logic scl_level;
    } res_t;

endpackage

[hw/rtl/i2cdw_front.sv]
// Input side: classifies stream items and holds them in a two-entry queue.
module i2cdw_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [23:0]            s_tdata,   // device_address[7:0], data_mode[8], payload[16:9]
    input  logic                   s_tuser,   // kind
    output logic                   head_valid,
    input  logic                   head_ready,
    output i2cdw_pkg::q_item_t     head_item
);
    import i2cdw_pkg::*;

    q_item_t    entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;
    q_item_t    new_item;

    // Build the frame bytes from the request fields.
    always_comb
    begin
        new_item.is_req = (s_tuser == KIND_REQUEST);
        new_item.frame  = {s_tdata[7:0], (s_tdata[8] ? CTRL_DATA : CTRL_COMMAND),
                           s_tdata[16:9]};
    end

    assign s_tready   = (count_reg != 2'd2);
    assign push       = s_tvalid && s_tready;
    assign head_valid = (count_reg != 2'd0);
    assign pop        = head_valid && head_ready;
    assign head_item  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

[hw/rtl/i2cdw_engine.sv]
// Back side: bus phase sequencer, pin registers and the result register.
module i2cdw_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_data,
    input  logic                item_valid,
    output logic                item_ready,
    input  i2cdw_pkg::q_item_t  item,
    output logic                res_valid,
    input  logic                res_ready,
    output i2cdw_pkg::res_t     res
);
    import i2cdw_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_START1 = 9'b000000010,
        ST_START2 = 9'b000000100,
        ST_START3 = 9'b000001000,
        ST_BIT    = 9'b000010000,
        ST_ACK_HI = 9'b000100000,
        ST_ACK_LO = 9'b001000000,
        ST_STOP1  = 9'b010000000,
        ST_STOP2  = 9'b100000000
    } stage_t;

    stage_t                state_reg, state_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [1:0]            sub_reg, sub_next;
    logic [7:0]            tick_reg, tick_next;
    logic [7:0]            ticks_reg;
    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic                  scl_reg, scl_next;
    logic                  sda_reg, sda_next;
    logic                  out_valid_reg;
    res_t                  res_reg, res_next;
    logic                  take;
    logic                  accepted;
    logic                  done;
    logic                  advance;
    logic [7:0]            limit;
    logic [7:0]            tick_inc;

    assign item_ready = !out_valid_reg || res_ready;
    assign take       = item_valid && item_ready;
    assign res_valid  = out_valid_reg;
    assign res        = res_reg;

    assign limit    = (ticks_reg == 8'd0) ? 8'd1 : ticks_reg;
    assign tick_inc = tick_reg + 8'd1;

    // Phase sequencing for one item.
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        sub_next   = sub_reg;
        tick_next  = tick_reg;
        frame_next = frame_reg;
        accepted   = 1'b0;
        done       = 1'b0;
        advance    = 1'b0;
        if (item.is_req)
        begin
            if (state_reg == ST_IDLE)
            begin
                frame_next = item.frame;
                state_next = ST_START1;
                tick_next  = 8'd0;
                accepted   = 1'b1;
            end
        end
        else if (state_reg != ST_IDLE)
        begin
            tick_next = tick_inc;
            if (tick_inc >= limit)
            begin
                tick_next = 8'd0;
                advance   = 1'b1;
            end
        end
        if (advance)
        begin
            unique case (state_reg)
                ST_START1: state_next = ST_START2;
                ST_START2: state_next = ST_START3;
                ST_START3:
                begin
                    state_next = ST_BIT;
                    pos_next   = POS_W'(FRAME_BITS - 1);
                    sub_next   = 2'd0;
                end
                ST_BIT:
                begin
                    if (sub_reg != 2'd2)
                    begin
                        sub_next = sub_reg + 2'd1;
                    end
                    else if (pos_reg[2:0] == 3'd0)
                    begin
                        state_next = ST_ACK_HI;
                    end
                    else
                    begin
                        pos_next = pos_reg - POS_W'(1);
                        sub_next = 2'd0;
                    end
                end
                ST_ACK_HI: state_next = ST_ACK_LO;
                ST_ACK_LO:
                begin
                    if (pos_reg == POS_W'(0))
                    begin
                        state_next = ST_STOP1;
                    end
                    else
                    begin
                        state_next = ST_BIT;
                        pos_next   = pos_reg - POS_W'(1);
                        sub_next   = 2'd0;
                    end
                end
                ST_STOP1: state_next = ST_STOP2;
                ST_STOP2:
                begin
                    state_next = ST_IDLE;
                    done       = 1'b1;
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end

    // Pin levels for the phase being entered.
    always_comb
    begin
        scl_next = scl_reg;
        sda_next = sda_reg;
        if (accepted || advance)
        begin
            unique case (state_next)
                ST_IDLE:   begin scl_next = 1'b1; sda_next = 1'b1; end
                ST_START1: begin scl_next = 1'b1; sda_next = 1'b1; end
                ST_START2: begin scl_next = 1'b1; sda_next = 1'b0; end
                ST_START3: begin scl_next = 1'b0; sda_next = 1'b0; end
                ST_BIT:
                begin
                    scl_next = (sub_next == 2'd1);
                    sda_next = frame_reg[pos_next];
                end
                ST_ACK_HI: begin scl_next = 1'b1; sda_next = 1'b1; end
                ST_ACK_LO: begin scl_next = 1'b0; sda_next = 1'b1; end
                ST_STOP1:  begin scl_next = 1'b1; sda_next = 1'b0; end
                ST_STOP2:  begin scl_next = 1'b1; sda_next = 1'b1; end
                default:   begin scl_next = 1'b1; sda_next = 1'b1; end
            endcase
        end
    end

    // Result fields after this item.
    always_comb
    begin
        res_next.scl_level = scl_next;
        res_next.sda_level = sda_next;
        res_next.busy_res  = (state_next != ST_IDLE);
        res_next.accepted  = accepted;
        res_next.done_res  = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            sub_reg       <= 2'd0;
            tick_reg      <= 8'd0;
            ticks_reg     <= TICKS_RESET;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ticks_reg <= cfg_data;
            end
            if (take)
            begin
                state_reg <= state_next;
                pos_reg   <= pos_next;
                sub_reg   <= sub_next;
                tick_reg  <= tick_next;
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
            end
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            frame_reg <= frame_next;
            res_reg   <= res_next;
        end
    end

endmodule

[hw/rtl/i2c_display_write_master.sv]
// Top level of the write-only I2C master for a display controller.
//
//  Channel   Direction  Handshake            Contents
//  s_*       in         s_tvalid / s_tready  tick or transfer request
//  m_*       out        m_tvalid / m_tready  pin levels, busy, accepted, done
//  cfg_*     in         cfg_we               phase_ticks register
//
// One item per cycle is sustained while m_tready is high: each item updates the phase
// sequencer at once, and the result register frees as the next result is loaded.
// An input transaction reaches the result through the queue entry and the result register.
// Reset is asynchronous, active low; the pins come out of reset released.
// A stall on m_* backs up the two-entry queue, which then drops s_tready.
module i2c_display_write_master (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // device_address[7:0], data_mode[8], payload[16:9]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // scl_level[0], sda_level[1], busy_res[2], accepted[3],
                                   // done_res[4]
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data
);
    import i2cdw_pkg::*;

    q_item_t head_item;
    logic    head_valid;
    logic    head_ready;
    res_t    res;

    i2cdw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .head_valid (head_valid),
        .head_ready (head_ready),
        .head_item  (head_item)
    );

    i2cdw_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .item_valid (head_valid),
        .item_ready (head_ready),
        .item       (head_item),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = {3'b000, res};

endmodule

[hw/rtl/i2cdw_checker.sv]
// Port-level checks for the display write I2C master, bound to the top level.
module i2cdw_port_checks (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // A frame cannot start and end on the same item.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[3] && m_tdata[4]))
        else $error("accepted and done together");

    // Starting a frame makes the block busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> m_tdata[2])
        else $error("accepted without busy");

    // The end of a frame leaves the block idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4] |-> !m_tdata[2])
        else $error("done while still busy");

    // While idle both lines are released.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[2] |-> m_tdata[0] && m_tdata[1])
        else $error("bus not released while idle");

endmodule

bind i2c_display_write_master i2cdw_port_checks u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[bench/i2cdw_checker.sv]
// Checker for the display write I2C master: predicts every result and compares it.
module i2cdw_checker
    import i2cdw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // device_address[7:0], data_mode[8], payload[16:9]
    input  logic        s_tuser,   // kind
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // scl_level[0], sda_level[1], busy_res[2], accepted[3],
                                   // done_res[4]
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    output int          fail_count,
    output int          pending,
    output logic        frame_busy,
    output int          items_seen,
    output int          frames_started,
    output int          frames_done
);

    timeunit 1ns;
    timeprecision 1ps;

    // Bus phase layout of one frame.
    localparam int START_PHASES = 3;
    localparam int BYTE_PHASES  = 26;
    localparam int BIT_PHASES   = 24;
    localparam int LAST_PHASE   = START_PHASES + FRAME_BYTES * BYTE_PHASES + 2;

    // Local copy of the sequencer state and the phase length register.
    logic [7:0]            ticks_cfg;
    logic [6:0]            phase;
    logic [7:0]            held;
    logic [FRAME_BITS-1:0] shifter;
    logic                  scl_q;
    logic                  sda_q;
    logic                  busy_q;

    // Results (pin levels and flags) still owed by the block, oldest first.
    res_t expected_pins_q[$];

    // Pin levels {scl, sda} that a given phase drives.
    function automatic logic [1:0] pins_for_phase(input int ph, input logic [FRAME_BITS-1:0] fr);
        int q;
        int slot;
        int bitn;
        int sub;
        if (ph == 1)
            return 2'b11;
        if (ph == 2)
            return 2'b10;
        if (ph == 3)
            return 2'b00;
        if (ph <= START_PHASES + FRAME_BYTES * BYTE_PHASES)
        begin
            q    = ph - START_PHASES - 1;
            slot = q % BYTE_PHASES;
            // Data bits MSB first: set up with SCL low, clock high, clock low.
            if (slot < BIT_PHASES)
            begin
                bitn = (q / BYTE_PHASES) * 8 + slot / 3;
                sub  = slot % 3;
                return {sub == 1, fr[FRAME_BITS-1-bitn]};
            end
            // Acknowledge clock with SDA released.
            return {slot == BIT_PHASES, 1'b1};
        end
        if (ph == LAST_PHASE - 1)
            return 2'b10;
        return 2'b11;
    endfunction

    // Apply one input item to the local sequencer and return the result it causes.
    function automatic res_t step_sequencer(input logic kind, input logic [23:0] data);
        res_t       r;
        logic [7:0] limit;
        r = '0;
        if (kind == KIND_REQUEST)
        begin
            // A request only starts a frame while the bus is idle.
            if (!busy_q)
            begin
                shifter = {data[7:0], data[8] ? CTRL_DATA : CTRL_COMMAND, data[16:9]};
                busy_q  = 1'b1;
                phase   = 7'd1;
                held    = 8'd0;
                {scl_q, sda_q} = pins_for_phase(1, shifter);
                r.accepted = 1'b1;
            end
        end
        else if (busy_q)
        begin
            // A zero phase length behaves as one tick per phase.
            limit = (ticks_cfg == 8'd0) ? 8'd1 : ticks_cfg;
            held  = held + 8'd1;
            if (held >= limit)
            begin
                held = 8'd0;
                if (phase >= LAST_PHASE)
                begin
                    phase      = 7'd0;
                    busy_q     = 1'b0;
                    scl_q      = 1'b1;
                    sda_q      = 1'b1;
                    r.done_res = 1'b1;
                end
                else
                begin
                    phase = phase + 7'd1;
                    {scl_q, sda_q} = pins_for_phase(phase, shifter);
                end
            end
        end
        r.scl_level = scl_q;
        r.sda_level = sda_q;
        r.busy_res  = busy_q;
        return r;
    endfunction

    // Predict on each input transaction, compare on each output transaction.
    always @(posedge clk or negedge rst_n)
    begin
        res_t got;
        res_t want;
        res_t nxt;
        if (!rst_n)
        begin
            ticks_cfg      = TICKS_RESET;
            phase          = 7'd0;
            held           = 8'd0;
            shifter        = '0;
            scl_q          = 1'b1;
            sda_q          = 1'b1;
            busy_q         = 1'b0;
            fail_count     = 0;
            items_seen     = 0;
            frames_started = 0;
            frames_done    = 0;
            expected_pins_q.delete();
            pending    <= 0;
            frame_busy <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                ticks_cfg = cfg_data;

            if (s_tvalid && s_tready)
            begin
                nxt = step_sequencer(s_tuser, s_tdata);
                expected_pins_q.push_back(nxt);
                items_seen++;
                if (nxt.accepted)
                    frames_started++;
                if (nxt.done_res)
                    frames_done++;
            end

            if (m_tvalid && m_tready)
            begin
                got = res_t'(m_tdata[4:0]);
                if (expected_pins_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result %b arrived with nothing expected", $time, got);
                end
                else
                begin
                    want = expected_pins_q.pop_front();
                    if (got.scl_level !== want.scl_level || got.sda_level !== want.sda_level ||
                        got.busy_res !== want.busy_res || got.accepted !== want.accepted ||
                        got.done_res !== want.done_res)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: mismatch (expected/actual) scl %b/%b sda %b/%b ",
                                      "busy %b/%b accepted %b/%b done %b/%b"}, $time,
                                     want.scl_level, got.scl_level, want.sda_level,
                                     got.sda_level, want.busy_res, got.busy_res,
                                     want.accepted, got.accepted, want.done_res, got.done_res);
                    end
                end
            end

            pending    <= expected_pins_q.size();
            frame_busy <= busy_q;
        end
    end

endmodule

[bench/tb.sv]
// Testbench top for the display write I2C master: stimulus, stalls and verdict.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import i2cdw_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // device_address[7:0], data_mode[8], payload[16:9]
    logic        s_tuser;   // kind
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // scl_level[0], sda_level[1], busy_res[2], accepted[3],
                            // done_res[4]
    logic        cfg_we;
    logic [7:0]  cfg_data;

    int   fail_count;
    int   pending;
    logic frame_busy;
    int   items_seen;
    int   frames_started;
    int   frames_done;

    // When set, neither side inserts idle cycles.
    bit quiet;

    i2c_display_write_master u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    i2cdw_checker u_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending),
        .frame_busy     (frame_busy),
        .items_seen     (items_seen),
        .frames_started (frames_started),
        .frames_done    (frames_done)
    );

    // Clock with a 2 ns period.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result side: random stall bursts between stretches of readiness.
    initial
    begin
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    // Present one item and hold it until the block takes the transaction.
    task automatic send_item(input logic kind, input logic [7:0] addr, input logic mode,
                             input logic [7:0] pay);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_tuser  <= kind;
        s_tdata  <= {7'd0, pay, mode, addr};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_tick();
        send_item(KIND_TICK, 8'($urandom), 1'($urandom), 8'($urandom));
    endtask

    task automatic send_random_request();
        send_item(KIND_REQUEST, 8'($urandom), 1'($urandom), 8'($urandom));
    endtask

    // Stop sending and wait until every predicted result has been checked.
    task automatic wait_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Keep ticking until the frame in flight has ended and the block is idle.
    task automatic finish_frame();
        wait_results();
        while (frame_busy)
        begin
            repeat (16) send_tick();
            wait_results();
        end
    endtask

    // Phase length write; the input is drained first so no transaction is in flight.
    task automatic write_phase_ticks(input logic [7:0] value);
        wait_results();
        cfg_data <= value;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Mix of ticks and requests; requests while busy are dropped by the block.
    task automatic run_random(input int count);
        repeat (count)
        begin
            if ($urandom_range(0, 4) == 0)
                send_random_request();
            else
                send_tick();
            if ($urandom_range(0, 59) == 0)
                wait_results();
        end
    endtask

    // Main stimulus sequence.
    initial
    begin
        s_tvalid <= 1'b0;
        s_tuser  <= KIND_TICK;
        s_tdata  <= '0;
        cfg_we   <= 1'b0;
        cfg_data <= '0;
        rst_n    <= 1'b0;
        quiet = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset phase length: idle ticks, a frame start, and a request while busy.
        send_tick();
        send_tick();
        send_item(KIND_REQUEST, 8'hA5, 1'b0, 8'h3C);
        send_item(KIND_REQUEST, 8'h5A, 1'b1, 8'hC3);
        repeat (22) send_tick();

        // Shorten the phases in the middle of that frame and let it finish.
        write_phase_ticks(8'd1);
        finish_frame();

        // One tick per phase with all-ones fields, then zero phase length with all zeros.
        send_item(KIND_REQUEST, 8'hFF, 1'b1, 8'hFF);
        finish_frame();
        send_tick();
        write_phase_ticks(8'd0);
        send_item(KIND_REQUEST, 8'h00, 1'b0, 8'h00);
        send_item(KIND_REQUEST, 8'hFF, 1'b1, 8'hFF);
        finish_frame();

        // Random segments over several short phase lengths.
        for (int seg = 0; seg < 6; seg++)
        begin
            write_phase_ticks(seg < 3 ? 8'(seg + 1) : 8'($urandom_range(1, 2)));
            quiet = (seg == 3);
            run_random(90);
            finish_frame();
        end

        // Longest phase length, with no idling on either side.
        quiet = 1'b1;
        write_phase_ticks(8'd255);
        send_random_request();
        repeat (120)
        begin
            if ($urandom_range(0, 19) == 0)
                send_random_request();
            else
                send_tick();
        end
        wait_results();
        repeat (8) @(posedge clk);

        $display("Run covered %0d items, %0d frames started and %0d completed,",
                 items_seen, frames_started, frames_done);
        $display("phase lengths of 0, 1, 20, 255 and several random short values.");
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Hard limit on simulated time.
    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
